[rtl/nconv_pkg.sv]
// ----------------------------------------------------------------------------
// nconv_pkg
// Shared types, constants and helpers for the normalised 3x3 convolution.
// ----------------------------------------------------------------------------
package nconv_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int DimW      = 11;
  localparam int AccW      = 20;
  localparam int SumW      = 12;
  localparam int QW        = AccW + 1;

  localparam logic [2:0] RegColorMode = 3'd0;
  localparam logic [2:0] RegWidth     = 3'd1;
  localparam logic [2:0] RegHeight    = 3'd2;
  localparam logic [2:0] RegMaskTop   = 3'd3;
  localparam logic [2:0] RegMaskMid   = 3'd4;
  localparam logic [2:0] RegMaskBot   = 3'd5;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [9:0] out_x;
    logic [9:0] out_y;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       zero_divisor;
  } pixel_out_t;

  // request from window stage to the divide unit
  typedef struct packed {
    logic                  valid;
    logic [9:0]            x;
    logic [9:0]            y;
    logic                  zd;
    logic                  rgb;
    logic signed [AccW-1:0] acc0;
    logic signed [AccW-1:0] acc1;
    logic signed [AccW-1:0] acc2;
  } div_req_t;

  function automatic logic [7:0] sat8(input logic signed [QW-1:0] q);
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

endpackage

[rtl/nconv_ram.sv]
// ----------------------------------------------------------------------------
// nconv_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module nconv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/nconv_div.sv]
// ----------------------------------------------------------------------------
// nconv_div
// Sequential signed divider, one quotient bit per cycle, three channels.
// ----------------------------------------------------------------------------
module nconv_div (
  input  logic                          clk,
  input  logic                          rst,
  input  nconv_pkg::div_req_t           req,
  input  logic signed [nconv_pkg::SumW-1:0] divisor,
  output logic                          done,
  output nconv_pkg::pixel_out_t         result
);
  localparam int AccW = nconv_pkg::AccW;
  localparam int CntW = $clog2(AccW + 1);

  typedef enum logic [1:0] {IDLE, RUN, FIN} state_t;
  state_t state;

  logic [CntW-1:0] cnt;
  logic [AccW-1:0] quo [3];
  logic [AccW:0]   rem [3];
  logic [AccW-1:0] mag [3];
  logic            neg [3];
  logic [nconv_pkg::SumW-1:0] dmag;
  logic [9:0] x, y;
  logic zd, rgb;

  logic [AccW:0] trial [3];
  logic signed [nconv_pkg::QW-1:0] q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem[c][AccW-1:0], mag[c][AccW-1]};
      q[c] = neg[c] ? -$signed({1'b0, quo[c][nconv_pkg::QW-2:0]})
                    : $signed({1'b0, quo[c][nconv_pkg::QW-2:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (req.valid) begin
            logic signed [AccW-1:0] a [3];
            a[0] = req.acc0; a[1] = req.acc1; a[2] = req.acc2;
            for (int c = 0; c < 3; c++) begin
              mag[c] <= a[c][AccW-1] ? AccW'(-a[c]) : AccW'(a[c]);
              rem[c] <= '0;
              quo[c] <= '0;
            end
            dmag  <= divisor[nconv_pkg::SumW-1] ? nconv_pkg::SumW'(-divisor)
                                                  : nconv_pkg::SumW'(divisor);
            x <= req.x; y <= req.y; zd <= req.zd; rgb <= req.rgb;
            cnt   <= '0;
            state <= req.zd ? FIN : RUN;
          end
        end
        RUN: begin
          for (int c = 0; c < 3; c++) begin
            if (trial[c] >= (AccW+1)'(dmag)) begin
              rem[c] <= trial[c] - (AccW+1)'(dmag);
              quo[c] <= {quo[c][AccW-2:0], 1'b1};
            end else begin
              rem[c] <= trial[c];
              quo[c] <= {quo[c][AccW-2:0], 1'b0};
            end
            mag[c] <= {mag[c][AccW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(AccW - 1)) state <= FIN;
        end
        FIN: begin
          result.out_x <= x;
          result.out_y <= y;
          result.zero_divisor <= zd;
          if (zd) begin
            result.out_red <= '0; result.out_green <= '0; result.out_blue <= '0;
          end else begin
            result.out_red   <= nconv_pkg::sat8(q[0]);
            result.out_green <= rgb ? nconv_pkg::sat8(q[1]) : nconv_pkg::sat8(q[0]);
            result.out_blue  <= rgb ? nconv_pkg::sat8(q[2]) : nconv_pkg::sat8(q[0]);
          end
          done  <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // sign flags captured at request time
  always_ff @(posedge clk) begin
    if (state == IDLE && req.valid) begin
      neg[0] <= req.acc0[AccW-1] ^ divisor[nconv_pkg::SumW-1];
      neg[1] <= req.acc1[AccW-1] ^ divisor[nconv_pkg::SumW-1];
      neg[2] <= req.acc2[AccW-1] ^ divisor[nconv_pkg::SumW-1];
    end
  end
endmodule

[rtl/normalized_convolution_3x3.sv]
// ----------------------------------------------------------------------------
// normalized_convolution_3x3
// Normalised 3x3 convolution over an rgb raster stream using two line stores.
// ----------------------------------------------------------------------------
// one pixel transaction at a time: line store read, window update, then for
// interior pixels a multiply-accumulate state and a 20-step serial divide
// (skipped with a zero coefficient sum); border pixels end after the window
// update. in_stall holds off a new pixel until the result transaction is
// taken; the next pixel is accepted in the cycle after that.
// reset (synchronous, rst high): counters and window cleared, identity mask,
// 640x480, grey mode; line store contents stay undefined.
module normalized_convolution_3x3 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  nconv_pkg::pixel_in_t        in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output nconv_pkg::pixel_out_t       out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  localparam int ColW = nconv_pkg::ColW;
  localparam int AccW = nconv_pkg::AccW;

  // config registers
  logic                   color_mode;
  logic [nconv_pkg::DimW-1:0] image_width, image_height;
  logic [23:0]            mask [3];
  logic signed [nconv_pkg::SumW-1:0] coef_sum;

  assign pready = 1'b1;
  logic wr;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= 1'b0;
      image_width  <= 11'd640;
      image_height <= 11'd480;
      mask[0] <= 24'd0;
      mask[1] <= 24'd256;
      mask[2] <= 24'd0;
    end else if (wr) begin
      unique case (paddr[4:2])
        nconv_pkg::RegColorMode: color_mode   <= pwdata[0];
        nconv_pkg::RegWidth:     image_width  <= pwdata[10:0];
        nconv_pkg::RegHeight:    image_height <= pwdata[10:0];
        nconv_pkg::RegMaskTop:   mask[0]      <= pwdata[23:0];
        nconv_pkg::RegMaskMid:   mask[1]      <= pwdata[23:0];
        nconv_pkg::RegMaskBot:   mask[2]      <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      nconv_pkg::RegColorMode: prdata = {31'd0, color_mode};
      nconv_pkg::RegWidth:     prdata = {21'd0, image_width};
      nconv_pkg::RegHeight:    prdata = {21'd0, image_height};
      nconv_pkg::RegMaskTop:   prdata = {8'd0, mask[0]};
      nconv_pkg::RegMaskMid:   prdata = {8'd0, mask[1]};
      nconv_pkg::RegMaskBot:   prdata = {8'd0, mask[2]};
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    coef_sum = '0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        coef_sum = coef_sum + nconv_pkg::SumW'($signed(mask[r][8*c +: 8]));
  end

  // clamped geometry
  logic [nconv_pkg::DimW-1:0] w_cl, h_cl;
  always_comb begin
    w_cl = (image_width < 11'd3) ? 11'd3 :
           (image_width > 11'(nconv_pkg::MaxWidth)) ? 11'(nconv_pkg::MaxWidth) : image_width;
    h_cl = (image_height < 11'd3) ? 11'd3 :
           (image_height > 11'(nconv_pkg::MaxHeight)) ? 11'(nconv_pkg::MaxHeight) : image_height;
  end

  typedef enum logic [2:0] {S_IDLE, S_READ, S_WIN, S_MAC, S_DIV, S_OUT} state_t;
  state_t state;

  logic [10:0] col_cnt, row_cnt;
  logic [ColW-1:0] col;
  logic [9:0] row;
  logic [23:0] pix;
  logic [23:0] win [9];

  // line store: two memories, up1 row and up2 row
  logic ls_we;
  logic [23:0] up1, up2;
  nconv_ram #(.Width(24), .Depth(nconv_pkg::MaxWidth)) u_ls1 (
    .clk(clk), .we(ls_we), .addr(col), .wdata(pix), .rdata(up1));
  nconv_ram #(.Width(24), .Depth(nconv_pkg::MaxWidth)) u_ls2 (
    .clk(clk), .we(ls_we), .addr(col), .wdata(up1), .rdata(up2));
  assign ls_we = (state == S_WIN);

  // multiply-accumulate over window
  logic signed [AccW-1:0] acc [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = '0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          acc[ch] = acc[ch] + AccW'($signed(mask[r][8*c +: 8]) *
                    $signed({1'b0, win[r*3+c][8*ch +: 8]}));
    end
  end

  nconv_pkg::div_req_t req;
  logic div_done;
  nconv_pkg::pixel_out_t div_res;

  nconv_div u_div (
    .clk(clk), .rst(rst), .req(req), .divisor(coef_sum),
    .done(div_done), .result(div_res));

  assign in_stall = (state != S_IDLE);
  logic interior;
  assign interior = (row >= 10'd2) && (col >= ColW'(2));

  logic [10:0] c_eff, r_eff;
  always_comb begin
    c_eff = col_cnt; r_eff = row_cnt;
    if (c_eff >= w_cl) begin c_eff = '0; r_eff = r_eff + 1'b1; end
    if (r_eff >= h_cl) r_eff = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      col_cnt <= '0; row_cnt <= '0;
      col <= '0; row <= '0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
      req.valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      req.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            // channel 0 in the low byte
            pix <= {in_data.pixel_blue, in_data.pixel_green, in_data.pixel_red};
            col <= ColW'(c_eff);
            row <= r_eff[9:0];
            state <= S_READ;
          end
        end
        S_READ: state <= S_WIN;
        S_WIN: begin
          for (int r = 0; r < 3; r++) begin
            win[r*3]   <= win[r*3+1];
            win[r*3+1] <= win[r*3+2];
          end
          win[2] <= up2; win[5] <= up1; win[8] <= pix;
          if (11'(col) + 11'd1 >= w_cl) begin
            col_cnt <= '0;
            row_cnt <= ((11'(row) + 11'd1) >= h_cl) ? 11'd0 : 11'(row) + 11'd1;
          end else begin
            col_cnt <= 11'(col) + 11'd1;
            row_cnt <= 11'(row);
          end
          state <= interior ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          req.valid <= 1'b1;
          req.x <= 10'(col) - 10'd1;
          req.y <= row - 10'd1;
          req.zd <= (coef_sum == '0);
          req.rgb <= color_mode;
          req.acc0 <= acc[0]; req.acc1 <= acc[1]; req.acc2 <= acc[2];
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            out_data  <= div_res;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
